[sv/pcc_pkg.sv]
// Shared types, codes and reset constants of the prefix code codec.
// No dependencies; every other file of the block refers to this package by scoped names.
package pcc_pkg;

   localparam int MAX_RULES_DEF = 4;
   localparam int RES_MAX       = 8;   // most results one transaction can cause
   localparam int RES_IDX_W     = 3;
   localparam int RES_CNT_W     = 4;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 20;
   localparam int USE_W         = 3;

   // commands
   localparam logic [1:0] CMD_DECODE = 2'd0;
   localparam logic [1:0] CMD_ENCODE = 2'd1;
   localparam logic [1:0] CMD_FLUSH  = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_SYMBOL  = 2'd0;
   localparam logic [1:0] KIND_PACKED  = 2'd1;
   localparam logic [1:0] KIND_PADDED  = 2'd2;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RULE_ZERO    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RULES_IN_USE = 3'd4;

   typedef struct packed {
      logic [3:0] len;
      logic [7:0] code;
      logic [7:0] sym;
   } rule_type;

   localparam rule_type RULE_ZERO_RST  = 20'h10045;
   localparam rule_type RULE_ONE_RST   = 20'h20241;
   localparam rule_type RULE_TWO_RST   = 20'h30654;
   localparam rule_type RULE_THREE_RST = 20'h3074E;
   localparam logic [USE_W-1:0] RULES_IN_USE_RST = 3'd4;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [7:0] store;
      logic [2:0] fill;
   } pack_type;

   typedef struct packed {
      logic [RES_CNT_W-1:0]          num;
      logic [RES_MAX-1:0][1:0]       kind;
      logic [RES_MAX-1:0][7:0]       value;
   } batch_type;

   function automatic rule_type rule_reset(input int idx);
      rule_type r;
      case (idx)
         0:       r = RULE_ZERO_RST;
         1:       r = RULE_ONE_RST;
         2:       r = RULE_TWO_RST;
         default: r = RULE_THREE_RST;
      endcase
      return r;
   endfunction

endpackage

[sv/pcc_if.sv]
// Handshake channel interfaces of the prefix code codec: request, response, register write.
// Depends on pcc_pkg for field widths.
interface pcc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] data_byte;
   modport source (output valid, output command, output data_byte, input ready);
   modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface pcc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] value;
   logic       last;
   modport source (output valid, output kind, output value, output last, input ready);
   modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

interface pcc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [pcc_pkg::CSR_IDX_W-1:0]    index;
   logic [pcc_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/pcc_engine.sv]
// Combinational core of the prefix code codec: turns one staged transaction into its batch
// of results and the next encoder state. Depends on pcc_pkg.
module pcc_engine #(
   parameter int MAX_RULES = pcc_pkg::MAX_RULES_DEF
) (
   input  pcc_pkg::item_type                    item,
   input  pcc_pkg::rule_type [MAX_RULES-1:0]    rules,
   input  logic [pcc_pkg::USE_W-1:0]            n_active,
   input  pcc_pkg::pack_type                    pack,
   output pcc_pkg::pack_type                    pack_in,
   output pcc_pkg::batch_type                   batch
);

   logic [7:0]                      sh;
   logic [3:0]                      cnt;
   logic [pcc_pkg::RES_CNT_W-1:0]   res_n;
   logic                            hit;
   logic [7:0]                      hsym;
   logic                            found;
   logic [7:0]                      e_code;
   logic [3:0]                      e_len;
   logic [15:0]                     mask16;
   logic [14:0]                     code_m;
   logic [23:0]                     word;
   logic [4:0]                      total;
   logic [2:0]                      nfill;

   always_comb begin
      batch   = '0;
      pack_in = pack;
      sh      = 8'd0;
      cnt     = 4'd0;
      res_n   = '0;
      hit     = 1'b0;
      hsym    = 8'd0;
      found   = 1'b0;
      e_code  = 8'd0;
      e_len   = 4'd0;
      mask16  = 16'd0;
      code_m  = 15'd0;
      word    = 24'd0;
      total   = 5'd0;
      nfill   = 3'd0;
      case (item.command)
         pcc_pkg::CMD_DECODE: begin
            for (int i = 0; i < 8; i++) begin
               sh = {sh[6:0], item.data_byte[7-i]};
               if (cnt != 4'd8) begin
                  cnt = cnt + 4'd1;
               end
               hit  = 1'b0;
               hsym = 8'd0;
               // walk backwards so the first rule in order wins
               for (int r = MAX_RULES - 1; r >= 0; r--) begin
                  if (pcc_pkg::USE_W'(r) < n_active && cnt == rules[r].len &&
                      sh == rules[r].code) begin
                     hit  = 1'b1;
                     hsym = rules[r].sym;
                  end
               end
               if (hit) begin
                  batch.kind[res_n[pcc_pkg::RES_IDX_W-1:0]]  = pcc_pkg::KIND_SYMBOL;
                  batch.value[res_n[pcc_pkg::RES_IDX_W-1:0]] = hsym;
                  res_n = res_n + 4'd1;
                  sh    = 8'd0;
                  cnt   = 4'd0;
               end
            end
            batch.num = res_n;
         end
         pcc_pkg::CMD_ENCODE: begin
            for (int r = MAX_RULES - 1; r >= 0; r--) begin
               if (pcc_pkg::USE_W'(r) < n_active && rules[r].sym == item.data_byte) begin
                  found  = 1'b1;
                  e_code = rules[r].code;
                  e_len  = rules[r].len;
               end
            end
            if (found) begin
               // code bits above bit 7 read as zero; bits above the length are dropped
               mask16 = (16'd1 << e_len) - 16'd1;
               code_m = 15'({8'd0, e_code} & mask16);
               word   = (24'(pack.store) << e_len) | 24'(code_m);
               total  = 5'(pack.fill) + 5'(e_len);
               nfill  = total[2:0];
               batch.kind[0]  = pcc_pkg::KIND_PACKED;
               batch.kind[1]  = pcc_pkg::KIND_PACKED;
               batch.value[0] = 8'(word >> (total - 5'd8));
               batch.value[1] = 8'(word >> (total - 5'd16));
               batch.num      = pcc_pkg::RES_CNT_W'(total[4:3]);
               pack_in.fill   = nfill;
               pack_in.store  = word[7:0] & ((8'd1 << nfill) - 8'd1);
            end else begin
               batch.kind[0]  = pcc_pkg::KIND_UNKNOWN;
               batch.value[0] = item.data_byte;
               batch.num      = 4'd1;
            end
         end
         pcc_pkg::CMD_FLUSH: begin
            if (pack.fill != 3'd0) begin
               batch.kind[0]  = pcc_pkg::KIND_PADDED;
               batch.value[0] = 8'(pack.store << (4'd8 - 4'(pack.fill)));
               batch.num      = 4'd1;
            end
            pack_in = '0;
         end
         default: begin
            // unused command: no result, state kept
            batch = '0;
         end
      endcase
   end

endmodule

[sv/prefix_code_codec.sv]
// Top level of the prefix code codec: staging register, rule table, encoder state and
// result batch register. Depends on pcc_pkg, pcc_if and pcc_engine.
//
// A request transaction is accepted every cycle as long as the result side keeps up. Each
// request is held in the staging register until the batch register is free, then passes
// through the decode/encode logic into the batch register, which offers its first result.
// The batch register hands out one result per cycle while the response side is ready: a
// request with k results (decode up to 8, encode up to 2, flush 0 or 1, unknown symbol 1)
// occupies the response port until all k are taken, and the next request moves up in the
// cycle its last result is taken. A request without results offers none. Register writes
// are always accepted and take effect in the next cycle.
module prefix_code_codec #(
   parameter int MAX_RULES = pcc_pkg::MAX_RULES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pcc_req_if.sink    req_chan,
   pcc_rsp_if.source  rsp_chan,
   pcc_csr_if.sink    csr_chan
);

   pcc_pkg::rule_type [MAX_RULES-1:0]   rule_ff;
   logic [pcc_pkg::USE_W-1:0]           rules_in_use_ff;
   logic [pcc_pkg::USE_W-1:0]           n_active;

   logic                                stg_valid_ff;
   pcc_pkg::item_type                   stg_item_ff;

   pcc_pkg::pack_type                   pack_ff;
   pcc_pkg::pack_type                   pack_in;
   pcc_pkg::batch_type                  batch_in;

   logic                                bat_busy_ff;
   logic [pcc_pkg::RES_IDX_W-1:0]       bat_rd_ff;
   logic [pcc_pkg::RES_CNT_W-1:0]       bat_num_ff;
   logic [pcc_pkg::RES_MAX-1:0][1:0]    bat_kind_ff;
   logic [pcc_pkg::RES_MAX-1:0][7:0]    bat_value_ff;

   logic                                rsp_take;
   logic                                bat_last;
   logic                                bat_free;
   logic                                stg_advance;
   logic                                req_take;

   assign n_active = (rules_in_use_ff > pcc_pkg::USE_W'(MAX_RULES)) ?
                     pcc_pkg::USE_W'(MAX_RULES) : rules_in_use_ff;

   assign bat_last    = (pcc_pkg::RES_CNT_W'(bat_rd_ff) + 4'd1) == bat_num_ff;
   assign rsp_take    = bat_busy_ff && rsp_chan.ready;
   assign bat_free    = !bat_busy_ff || (rsp_take && bat_last);
   assign stg_advance = stg_valid_ff && bat_free;
   assign req_take    = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !stg_valid_ff || stg_advance;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid = bat_busy_ff;
   assign rsp_chan.kind  = bat_kind_ff[bat_rd_ff];
   assign rsp_chan.value = bat_value_ff[bat_rd_ff];
   assign rsp_chan.last  = bat_last;

   pcc_engine #(
      .MAX_RULES (MAX_RULES)
   ) u_engine (
      .item     (stg_item_ff),
      .rules    (rule_ff),
      .n_active (n_active),
      .pack     (pack_ff),
      .pack_in  (pack_in),
      .batch    (batch_in)
   );

   // register table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_RULES; i++) begin
            rule_ff[i] <= pcc_pkg::rule_reset(i);
         end
         rules_in_use_ff <= pcc_pkg::RULES_IN_USE_RST;
      end else if (csr_chan.valid) begin
         for (int i = 0; i < MAX_RULES; i++) begin
            if (csr_chan.index == pcc_pkg::CSR_RULE_ZERO + pcc_pkg::CSR_IDX_W'(i)) begin
               rule_ff[i] <= pcc_pkg::rule_type'(csr_chan.data);
            end
         end
         if (csr_chan.index == pcc_pkg::CSR_RULES_IN_USE) begin
            rules_in_use_ff <= csr_chan.data[pcc_pkg::USE_W-1:0];
         end
      end
   end

   // staging register
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         stg_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stg_item_ff <= '{command: req_chan.command, data_byte: req_chan.data_byte};
      end
   end

   // encoder state advances with the transaction that leaves the staging register
   always_ff @(posedge clock) begin
      if (reset) begin
         pack_ff <= '0;
      end else if (stg_advance) begin
         pack_ff <= pack_in;
      end
   end

   // result batch control
   always_ff @(posedge clock) begin
      if (reset) begin
         bat_busy_ff <= 1'b0;
         bat_rd_ff   <= '0;
         bat_num_ff  <= '0;
      end else if (stg_advance) begin
         bat_busy_ff <= batch_in.num != '0;
         bat_rd_ff   <= '0;
         bat_num_ff  <= batch_in.num;
      end else if (rsp_take) begin
         if (bat_last) begin
            bat_busy_ff <= 1'b0;
         end else begin
            bat_rd_ff <= bat_rd_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stg_advance) begin
         bat_kind_ff  <= batch_in.kind;
         bat_value_ff <= batch_in.value;
      end
   end

endmodule

[sv/pcc_checker.sv]
// Port-level assertions of the prefix code codec and the bind that attaches them.
// Depends on pcc_pkg and the top level prefix_code_codec.
module pcc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic       rsp_last
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // results of one transaction come out without gaps
   a_rsp_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside a result burst");

   // unknown symbol and padded byte always stand alone
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == pcc_pkg::KIND_UNKNOWN || rsp_kind == pcc_pkg::KIND_PADDED)
      |-> rsp_last)
      else $error("single result not marked last");

   // reset empties the result batch
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind prefix_code_codec pcc_checker u_pcc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_kind  (rsp_chan.kind),
   .rsp_last  (rsp_chan.last)
);

[verif/prefix_code_codec_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for prefix_code_codec: directed script, then random rule tables and items.
// Depends on pcc_pkg, the pcc_*_if channel interfaces and the prefix_code_codec top level.
module prefix_code_codec_tb;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [pcc_pkg::CSR_IDX_W-1:0] CSR_RULE_ONE   = pcc_pkg::CSR_RULE_ZERO + 3'd1;
   localparam logic [pcc_pkg::CSR_IDX_W-1:0] CSR_RULE_TWO   = pcc_pkg::CSR_RULE_ZERO + 3'd2;
   localparam logic [pcc_pkg::CSR_IDX_W-1:0] CSR_RULE_THREE = pcc_pkg::CSR_RULE_ZERO + 3'd3;
   localparam int PREDICT        = -1;      // row expectation comes from the codec model
   localparam int SETTLE_CYCLES  = 8;
   localparam int LONG_HOLD      = 150;
   localparam int PHASES         = 6;
   localparam int PHASE_ITEMS    = 72;
   localparam int PRESSURE_PHASE = 2;
   localparam int CYCLE_LIMIT    = 400000;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic       last;
   } result_type;

   typedef struct packed {
      int         count;
      logic [1:0] kind;
      logic [7:0] value;
   } typed_result_type;

   typedef struct {
      bit                             is_csr;
      logic [pcc_pkg::CSR_IDX_W-1:0]  reg_index;
      logic [pcc_pkg::CSR_DATA_W-1:0] reg_data;
      pcc_pkg::item_type              item;
      typed_result_type               gold;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;

   pcc_req_if req_bus ();
   pcc_rsp_if rsp_bus ();
   pcc_csr_if csr_bus ();

   prefix_code_codec #(.MAX_RULES(pcc_pkg::MAX_RULES_DEF)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // codec model state
   pcc_pkg::rule_type         rule_tab [4];
   logic [pcc_pkg::USE_W-1:0] use_count;
   logic [7:0]                enc_store;
   int                        enc_fill;

   result_type       expected_q [$];
   result_type       scratch [$];
   result_type       want;
   typed_result_type offered_golden;
   script_row_type   script [$];

   int  failures = 0;
   int  results_checked = 0;
   int  requests_taken = 0;
   int  directed_items = 0;
   int  table_settings = 1;
   int  cycle_count = 0;
   int  stall_tickets = 0;
   int  stall_served = 0;
   int  hold_left = 0;
   bit  calm = 1'b0;

   function automatic void note_failure(input string what);
      failures++;
      if (failures <= 10)
         $display("mismatch: %s", what);
   endfunction

   function automatic int active_rules();
      return (use_count > pcc_pkg::MAX_RULES_DEF) ? pcc_pkg::MAX_RULES_DEF : int'(use_count);
   endfunction

   function automatic void predict_codec(input pcc_pkg::item_type it,
                                         ref result_type res [$]);
      logic [7:0]  shreg;
      logic [15:0] wide_code;
      int          bits;
      bit          hit;
      res.delete();
      case (it.command)
         pcc_pkg::CMD_DECODE: begin
            shreg = '0;
            bits  = 0;
            for (int i = 7; i >= 0; i--) begin
               shreg = {shreg[6:0], it.data_byte[i]};
               if (bits < 8)
                  bits++;
               for (int r = 0; r < active_rules(); r++) begin
                  if (bits == int'(rule_tab[r].len) && shreg == rule_tab[r].code) begin
                     res.push_back('{kind: pcc_pkg::KIND_SYMBOL, value: rule_tab[r].sym,
                                     last: 1'b0});
                     shreg = '0;
                     bits  = 0;
                     break;
                  end
               end
            end
         end
         pcc_pkg::CMD_ENCODE: begin
            hit = 1'b0;
            for (int r = 0; r < active_rules() && !hit; r++) begin
               if (rule_tab[r].sym == it.data_byte) begin
                  hit = 1'b1;
                  // positions above the 8-bit code shift in as zeros
                  wide_code = {8'h00, rule_tab[r].code};
                  for (int p = int'(rule_tab[r].len) - 1; p >= 0; p--) begin
                     enc_store = {enc_store[6:0], wide_code[p]};
                     enc_fill++;
                     if (enc_fill == 8) begin
                        res.push_back('{kind: pcc_pkg::KIND_PACKED, value: enc_store,
                                        last: 1'b0});
                        enc_store = '0;
                        enc_fill  = 0;
                     end
                  end
               end
            end
            if (!hit)
               res.push_back('{kind: pcc_pkg::KIND_UNKNOWN, value: it.data_byte, last: 1'b0});
         end
         pcc_pkg::CMD_FLUSH: begin
            if (enc_fill > 0)
               res.push_back('{kind: pcc_pkg::KIND_PADDED, value: enc_store << (8 - enc_fill),
                               last: 1'b0});
            enc_store = '0;
            enc_fill  = 0;
         end
         default: ;
      endcase
      if (res.size() > 0)
         res[res.size() - 1].last = 1'b1;
   endfunction

   // Fill a byte with codes of active rules, MSB first; the last may be cut, spare bits random.
   function automatic logic [7:0] compose_codes();
      logic [7:0] out;
      int         filled;
      int         r;
      out    = 8'($urandom);
      filled = 0;
      for (int tries = 0; tries < 8 && filled < 8 && active_rules() > 0; tries++) begin
         r = $urandom_range(0, active_rules() - 1);
         if (rule_tab[r].len >= 4'd1 && rule_tab[r].len <= 4'd8) begin
            for (int b = int'(rule_tab[r].len) - 1; b >= 0 && filled < 8; b--) begin
               out[7 - filled] = rule_tab[r].code[b];
               filled++;
            end
         end
      end
      return out;
   endfunction

   function automatic script_row_type req_row(input logic [1:0] cmd, input logic [7:0] data,
                                              input int count, input logic [1:0] kind,
                                              input logic [7:0] value);
      script_row_type row;
      row.is_csr    = 1'b0;
      row.reg_index = '0;
      row.reg_data  = '0;
      row.item      = {cmd, data};
      row.gold      = '{count: count, kind: kind, value: value};
      return row;
   endfunction

   function automatic script_row_type csr_row(input logic [pcc_pkg::CSR_IDX_W-1:0] idx,
                                              input logic [pcc_pkg::CSR_DATA_W-1:0] data);
      script_row_type row;
      row           = req_row(CMD_UNUSED, 8'h00, 0, pcc_pkg::KIND_SYMBOL, 8'h00);
      row.is_csr    = 1'b1;
      row.reg_index = idx;
      row.reg_data  = data;
      return row;
   endfunction

   task automatic send_request(input pcc_pkg::item_type it, input typed_result_type gold);
      req_bus.valid     <= 1'b1;
      req_bus.command   <= it.command;
      req_bus.data_byte <= it.data_byte;
      offered_golden    <= gold;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic write_register(input logic [pcc_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [pcc_pkg::CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      csr_bus.valid <= 1'b0;
      if (idx <= CSR_RULE_THREE)
         rule_tab[idx[1:0]] = data;
      else if (idx == pcc_pkg::CSR_RULES_IN_USE)
         use_count = data[pcc_pkg::USE_W-1:0];
      @(posedge clock);
   endtask

   // Drop valid, wait for every pending result, then let silent requests drain.
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_random_rules();
      pcc_pkg::rule_type         rl;
      logic [8:0]                mask;
      logic [pcc_pkg::USE_W-1:0] in_use;
      int                        pick;
      for (int i = 0; i < 4; i++) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)
            rl.len = 4'd0;
         else if (pick == 1)
            rl.len = 4'($urandom_range(9, 15));
         else if (pick < 10)
            rl.len = 4'($urandom_range(1, 3));
         else
            rl.len = 4'($urandom_range(1, 8));
         rl.code = 8'($urandom);
         mask    = (9'd1 << rl.len) - 9'd1;
         if ($urandom_range(0, 9) != 0)
            rl.code = rl.code & mask[7:0];
         rl.sym = 8'($urandom);
         write_register(pcc_pkg::CSR_IDX_W'(pcc_pkg::CSR_RULE_ZERO + i), rl);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0)
         in_use = '0;
      else if (pick == 1)
         in_use = pcc_pkg::USE_W'($urandom_range(5, 7));
      else if (pick == 2)
         in_use = pcc_pkg::USE_W'($urandom_range(1, 2));
      else
         in_use = pcc_pkg::USE_W'($urandom_range(3, 4));
      write_register(pcc_pkg::CSR_RULES_IN_USE, pcc_pkg::CSR_DATA_W'(in_use));
   endtask

   // response side: random backpressure bursts, plus one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         hold_left     <= 0;
         rsp_bus.ready <= 1'b1;
      end else if (stall_tickets != stall_served) begin
         stall_served  <= stall_tickets;
         hold_left     <= LONG_HOLD;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= (hold_left == 1);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         hold_left     <= $urandom_range(1, 8);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // scoreboard: check each result transaction, predict each request transaction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_checked++;
            if (expected_q.size() == 0) begin
               note_failure($sformatf("unexpected result kind=%0d value=%02h last=%0b",
                                      rsp_bus.kind, rsp_bus.value, rsp_bus.last));
            end else begin
               want = expected_q.pop_front();
               if (rsp_bus.kind !== want.kind || rsp_bus.value !== want.value ||
                   rsp_bus.last !== want.last)
                  note_failure($sformatf(
                     "result kind/value/last expected %0d/%02h/%0b got %0d/%02h/%0b",
                     want.kind, want.value, want.last,
                     rsp_bus.kind, rsp_bus.value, rsp_bus.last));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            requests_taken++;
            predict_codec(pcc_pkg::item_type'({req_bus.command, req_bus.data_byte}), scratch);
            if (offered_golden.count != PREDICT) begin
               scratch.delete();
               for (int k = 0; k < offered_golden.count; k++)
                  scratch.push_back('{kind: offered_golden.kind, value: offered_golden.value,
                                      last: (k == offered_golden.count - 1)});
            end
            foreach (scratch[k])
               expected_q.push_back(scratch[k]);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  expected_q.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      pcc_pkg::item_type it;
      typed_result_type  no_gold;
      int                roll;
      int                counted;
      bit                pressure_done;

      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.command   = pcc_pkg::CMD_DECODE;
      req_bus.data_byte = 8'h00;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = pcc_pkg::CSR_RULE_ZERO;
      csr_bus.data      = '0;
      offered_golden    = '{count: PREDICT, kind: pcc_pkg::KIND_SYMBOL, value: 8'h00};
      no_gold           = '{count: PREDICT, kind: pcc_pkg::KIND_SYMBOL, value: 8'h00};
      pressure_done     = 1'b0;
      rule_tab[0]       = pcc_pkg::RULE_ZERO_RST;
      rule_tab[1]       = pcc_pkg::RULE_ONE_RST;
      rule_tab[2]       = pcc_pkg::RULE_TWO_RST;
      rule_tab[3]       = pcc_pkg::RULE_THREE_RST;
      use_count         = pcc_pkg::RULES_IN_USE_RST;
      enc_store         = '0;
      enc_fill          = 0;

      // reset table: E=0/1, A=10/2, T=110/3, N=111/3
      script.push_back(req_row(pcc_pkg::CMD_DECODE, 8'h00, 8, pcc_pkg::KIND_SYMBOL, "E"));
      script.push_back(req_row(pcc_pkg::CMD_DECODE, 8'hFF, 2, pcc_pkg::KIND_SYMBOL, "N"));
      script.push_back(req_row(pcc_pkg::CMD_DECODE, 8'h9B, PREDICT,
                               pcc_pkg::KIND_SYMBOL, 8'h00));
      script.push_back(req_row(pcc_pkg::CMD_ENCODE, "Z", 1, pcc_pkg::KIND_UNKNOWN, "Z"));
      script.push_back(req_row(pcc_pkg::CMD_ENCODE, 8'h00, 1, pcc_pkg::KIND_UNKNOWN, 8'h00));
      script.push_back(req_row(pcc_pkg::CMD_ENCODE, 8'hFF, 1, pcc_pkg::KIND_UNKNOWN, 8'hFF));
      script.push_back(req_row(pcc_pkg::CMD_FLUSH, 8'h00, 0, pcc_pkg::KIND_PADDED, 8'h00));
      script.push_back(req_row(pcc_pkg::CMD_ENCODE, "E", 0, pcc_pkg::KIND_PACKED, 8'h00));
      script.push_back(req_row(pcc_pkg::CMD_ENCODE, "T", PREDICT, pcc_pkg::KIND_PACKED, 8'h00));
      script.push_back(req_row(pcc_pkg::CMD_ENCODE, "N", PREDICT, pcc_pkg::KIND_PACKED, 8'h00));
      script.push_back(req_row(pcc_pkg::CMD_DECODE, 8'h5A, PREDICT,
                               pcc_pkg::KIND_SYMBOL, 8'h00));
      script.push_back(req_row(pcc_pkg::CMD_ENCODE, "A", PREDICT, pcc_pkg::KIND_PACKED, 8'h00));
      script.push_back(req_row(pcc_pkg::CMD_FLUSH, 8'hFF, PREDICT,
                               pcc_pkg::KIND_PADDED, 8'h00));
      script.push_back(req_row(pcc_pkg::CMD_FLUSH, 8'h00, 0, pcc_pkg::KIND_PADDED, 8'h00));
      script.push_back(req_row(CMD_UNUSED, 8'hFF, 0, pcc_pkg::KIND_SYMBOL, 8'h00));
      // no rules searched: nothing decodes, every symbol is unknown
      script.push_back(csr_row(pcc_pkg::CSR_RULES_IN_USE, 20'd0));
      script.push_back(req_row(pcc_pkg::CMD_DECODE, 8'h00, 0, pcc_pkg::KIND_SYMBOL, 8'h00));
      script.push_back(req_row(pcc_pkg::CMD_ENCODE, "E", 1, pcc_pkg::KIND_UNKNOWN, "E"));
      // rule count above the table size saturates
      script.push_back(csr_row(pcc_pkg::CSR_RULES_IN_USE, 20'd7));
      script.push_back(req_row(pcc_pkg::CMD_DECODE, 8'hFF, 2, pcc_pkg::KIND_SYMBOL, "N"));
      // zero length, length past eight, code wider than its length, full-width rule
      script.push_back(csr_row(pcc_pkg::CSR_RULE_ZERO,
                               pcc_pkg::rule_type'{len: 4'd0, code: 8'h00, sym: "E"}));
      script.push_back(csr_row(CSR_RULE_ONE,
                               pcc_pkg::rule_type'{len: 4'd12, code: 8'hA5, sym: "L"}));
      script.push_back(csr_row(CSR_RULE_TWO,
                               pcc_pkg::rule_type'{len: 4'd3, code: 8'hFF, sym: "X"}));
      script.push_back(csr_row(CSR_RULE_THREE,
                               pcc_pkg::rule_type'{len: 4'd8, code: 8'hFF, sym: 8'hFF}));
      script.push_back(req_row(pcc_pkg::CMD_ENCODE, "E", 0, pcc_pkg::KIND_PACKED, 8'h00));
      script.push_back(req_row(pcc_pkg::CMD_ENCODE, "L", PREDICT, pcc_pkg::KIND_PACKED, 8'h00));
      script.push_back(req_row(pcc_pkg::CMD_ENCODE, "L", PREDICT, pcc_pkg::KIND_PACKED, 8'h00));
      script.push_back(req_row(pcc_pkg::CMD_DECODE, 8'hFF, 1, pcc_pkg::KIND_SYMBOL, 8'hFF));
      script.push_back(req_row(pcc_pkg::CMD_DECODE, 8'h00, 0, pcc_pkg::KIND_SYMBOL, 8'h00));
      script.push_back(req_row(pcc_pkg::CMD_ENCODE, 8'hFF, PREDICT,
                               pcc_pkg::KIND_PACKED, 8'h00));
      script.push_back(req_row(pcc_pkg::CMD_ENCODE, "X", PREDICT, pcc_pkg::KIND_PACKED, 8'h00));
      script.push_back(req_row(pcc_pkg::CMD_FLUSH, 8'h00, PREDICT,
                               pcc_pkg::KIND_PADDED, 8'h00));
      script.push_back(csr_row(pcc_pkg::CSR_RULE_ZERO, 20'd0));
      script.push_back(req_row(pcc_pkg::CMD_ENCODE, 8'h00, 0, pcc_pkg::KIND_PACKED, 8'h00));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[n]) begin
         if (script[n].is_csr) begin
            settle();
            write_register(script[n].reg_index, script[n].reg_data);
            table_settings++;
         end else begin
            send_request(script[n].item, script[n].gold);
            directed_items++;
            if ($urandom_range(0, 3) == 0)
               pause_sender($urandom_range(1, 8));
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         // quiet phases on both sides; the final phase has no idling at all
         calm <= (phase == PHASES - 1) || ($urandom_range(0, 3) == 0);
         load_random_rules();
         table_settings++;
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 20)
               it = {pcc_pkg::CMD_DECODE, compose_codes()};
            else if (roll < 35)
               it = {pcc_pkg::CMD_DECODE, 8'($urandom)};
            else if (roll < 80 && active_rules() > 0)
               it = {pcc_pkg::CMD_ENCODE, rule_tab[$urandom_range(0, active_rules() - 1)].sym};
            else if (roll < 88)
               it = {pcc_pkg::CMD_ENCODE, 8'($urandom)};
            else if (roll < 97)
               it = {pcc_pkg::CMD_FLUSH, 8'($urandom)};
            else
               it = {CMD_UNUSED, 8'($urandom)};
            if (it.command != CMD_UNUSED)
               counted++;
            send_request(it, no_gold);
            // hold the result side off while requests keep coming, so the input backs up
            if (phase == PRESSURE_PHASE && counted >= 20 && !pressure_done) begin
               stall_tickets <= stall_tickets + 1;
               pressure_done = 1'b1;
            end
            if (!calm && $urandom_range(0, 4) == 0)
               pause_sender($urandom_range(1, 8));
         end
      end

      settle();
      if (expected_q.size() != 0)
         note_failure($sformatf("%0d expected results never arrived", expected_q.size()));
      $display("run covered %0d requests (%0d scripted) across %0d rule-table settings,",
               requests_taken, directed_items, table_settings);
      $display("with %0d result transactions checked and %0d failures", results_checked,
               failures);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
